/* rtl/pid_corexy_step_mixer_unit_defines.svh */
// Assertion macros for the PID CoreXY step mixer.
// Included by the top level; expects clk and rst_n in scope.
`ifndef PID_COREXY_STEP_MIXER_UNIT_DEFINES_SVH
`define PID_COREXY_STEP_MIXER_UNIT_DEFINES_SVH

// Check cons in the same cycle as ante.
`define PCSM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define PCSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pcsm_pkg.sv */
// Shared types and constants for the PID CoreXY step mixer.
// No dependencies; imported by every module of the block.
package pcsm_pkg;

    localparam int MULT_BITS  = 16;
    localparam int GAIN_W     = 16;
    localparam int RATIO_W    = 16;
    localparam int OUT_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W      = $clog2(MULT_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_X       = 3'd0,
        CFG_KI_X       = 3'd1,
        CFG_KD_X       = 3'd2,
        CFG_KP_Y       = 3'd3,
        CFG_KI_Y       = 3'd4,
        CFG_KD_Y       = 3'd5,
        CFG_PID_ENABLE = 3'd6,
        CFG_STEP_RATIO = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic load;
        logic step;
        logic neg;
    } lane_ctl_t;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

endpackage

/* rtl/pcsm_lane.sv */
// Bit-serial multiply-accumulate lane: up to three operands times three multipliers.
// Depends on pcsm_pkg (lane_ctl_t, MULT_BITS).
module pcsm_lane #(
    parameter int OP_W = 14
) (
    input  logic                                           clk,
    input  pcsm_pkg::lane_ctl_t                            ctl,
    input  logic signed [OP_W-1:0]                         op0,
    input  logic signed [OP_W-1:0]                         op1,
    input  logic signed [OP_W-1:0]                         op2,
    input  logic        [pcsm_pkg::MULT_BITS-1:0]          mul0,
    input  logic        [pcsm_pkg::MULT_BITS-1:0]          mul1,
    input  logic        [pcsm_pkg::MULT_BITS-1:0]          mul2,
    output logic signed [OP_W+2+pcsm_pkg::MULT_BITS-1:0]   prod
);
    import pcsm_pkg::*;

    localparam int ACC_W = OP_W + 2;

    logic signed [OP_W-1:0]      op0_reg, op1_reg, op2_reg;
    logic        [MULT_BITS-1:0] mul0_reg, mul1_reg, mul2_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic        [MULT_BITS-1:0] lo_reg;
    logic signed [ACC_W:0]       t0, t1, t2, tsum, acc_ext, sum;

    always_comb
    begin
        t0      = mul0_reg[0] ? (ACC_W+1)'(op0_reg) : '0;
        t1      = mul1_reg[0] ? (ACC_W+1)'(op1_reg) : '0;
        t2      = mul2_reg[0] ? (ACC_W+1)'(op2_reg) : '0;
        tsum    = t0 + t1 + t2;
        acc_ext = (ACC_W+1)'(acc_reg);
        // the last bit of a two's complement multiplier carries negative weight
        sum     = ctl.neg ? (acc_ext - tsum) : (acc_ext + tsum);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op0_reg  <= op0;
            op1_reg  <= op1;
            op2_reg  <= op2;
            mul0_reg <= mul0;
            mul1_reg <= mul1;
            mul2_reg <= mul2;
            acc_reg  <= '0;
            lo_reg   <= '0;
        end
        else if (ctl.step)
        begin
            acc_reg  <= sum[ACC_W:1];
            lo_reg   <= {sum[0], lo_reg[MULT_BITS-1:1]};
            mul0_reg <= mul0_reg >> 1;
            mul1_reg <= mul1_reg >> 1;
            mul2_reg <= mul2_reg >> 1;
        end
    end

    assign prod = {acc_reg, lo_reg};

endmodule

/* rtl/pcsm_round.sv */
// Round to nearest (half away from zero) and saturate one mixer product to 24 bits.
// Depends on pcsm_pkg (OUT_W, OUT_MAX, OUT_MIN).
module pcsm_round #(
    parameter int P_W = 51,
    parameter int SH  = 16
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [P_W-1:0]               prod,
    output logic signed [pcsm_pkg::OUT_W-1:0]   sat
);
    import pcsm_pkg::*;

    localparam int R_W = P_W + 1 - SH;
    localparam logic signed [P_W:0] HALF    = (P_W+1)'(1) << (SH - 1);
    localparam logic signed [P_W:0] HALF_M1 = HALF - (P_W+1)'(1);

    logic signed [P_W:0]   biased;
    logic signed [R_W-1:0] rnd_reg;

    // negative values take half minus one so the floor shift rounds away from zero
    assign biased = (P_W+1)'(prod) + (prod[P_W-1] ? HALF_M1 : HALF);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnd_reg <= biased[P_W:SH];
        end
    end

    always_comb
    begin
        priority if (rnd_reg > R_W'(OUT_MAX))
        begin
            sat = OUT_MAX;
        end
        else if (rnd_reg < R_W'(OUT_MIN))
        begin
            sat = OUT_MIN;
        end
        else
        begin
            sat = rnd_reg[OUT_W-1:0];
        end
    end

endmodule

/* rtl/pid_corexy_step_mixer_unit.sv */
// Top level of the PID position corrector with CoreXY step mixer.
// Depends on pcsm_pkg, pcsm_lane, pcsm_round and the assertion macro header.
//
// channel | role      | handshake            | payload
// in      | request   | in_valid / in_ready  | target_x, target_y, actual_x, actual_y
// out     | result    | out_valid / out_ready| steps_a, steps_b
// cfg     | reg write | cfg_we               | cfg_addr, cfg_wdata
//
// A request passes from acceptance to the output register through these steps:
// one bit-serial pass over the 16 gain bits for the PID terms, mixer load, one
// pass over the 16 ratio bits for the mixer, rounding and saturate. in_ready is
// high only when idle, so the next request waits until this one leaves saturate.
// A result waiting on out_ready does not block the next request; a second result
// holds in the saturate step until the output register frees up.
// Reset (async, active low) restores the register defaults and clears integral
// and previous error; there is no clearing pass.
`include "pid_corexy_step_mixer_unit_defines.svh"

module pid_corexy_step_mixer_unit #(
    parameter int COORD_BITS     = 12,
    parameter int GAIN_FRAC_BITS = 8,
    parameter int INTEGRAL_LIMIT = 500
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic        [pcsm_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic        [pcsm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [COORD_BITS-1:0]           target_x,
    input  logic signed [COORD_BITS-1:0]           target_y,
    input  logic signed [COORD_BITS-1:0]           actual_x,
    input  logic signed [COORD_BITS-1:0]           actual_y,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [pcsm_pkg::OUT_W-1:0]      steps_a,
    output logic signed [pcsm_pkg::OUT_W-1:0]      steps_b
);
    import pcsm_pkg::*;

    // error, derivative and integral widths
    localparam int ERR_W    = COORD_BITS + 1;
    localparam int DIF_W    = COORD_BITS + 2;
    localparam int INT_W    = $clog2(INTEGRAL_LIMIT + 1) + 1;
    localparam int S_W      = ((INT_W > ERR_W) ? INT_W : ERR_W) + 1;
    // lane operand and product widths
    localparam int PID_OP_W = (DIF_W > INT_W) ? DIF_W : INT_W;
    localparam int PID_P_W  = PID_OP_W + 2 + MULT_BITS;
    localparam int MIX_OP_W = PID_P_W + 1;
    localparam int MIX_P_W  = MIX_OP_W + 2 + MULT_BITS;
    localparam int SH       = 2 * GAIN_FRAC_BITS;

    localparam logic signed [GAIN_W-1:0] ONE_GAIN  = GAIN_W'(1) << GAIN_FRAC_BITS;
    localparam logic        [RATIO_W-1:0] ONE_RATIO = RATIO_W'(1) << GAIN_FRAC_BITS;
    localparam logic signed [INT_W-1:0]  INT_POS   = INT_W'(INTEGRAL_LIMIT);
    localparam logic signed [INT_W-1:0]  INT_NEG   = -INT_POS;
    localparam logic signed [S_W-1:0]    LIM_POS_S = S_W'(INTEGRAL_LIMIT);
    localparam logic signed [S_W-1:0]    LIM_NEG_S = -LIM_POS_S;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PID   = 6'b000010,
        S_MIXLD = 6'b000100,
        S_MIX   = 6'b001000,
        S_RND   = 6'b010000,
        S_SAT   = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 cnt_last;
    logic                 accept;
    logic                 out_load;

    // configuration
    logic signed [GAIN_W-1:0]  kp_reg [2];
    logic signed [GAIN_W-1:0]  ki_reg [2];
    logic signed [GAIN_W-1:0]  kd_reg [2];
    logic                      pid_en_reg;
    logic        [RATIO_W-1:0] ratio_reg;

    // controller state
    logic signed [INT_W-1:0]   integ_reg [2];
    logic signed [ERR_W-1:0]   prev_reg [2];

    // per-axis front end
    logic signed [COORD_BITS-1:0] tgt [2];
    logic signed [COORD_BITS-1:0] act [2];
    logic signed [ERR_W-1:0]      err [2];
    logic signed [S_W-1:0]        isum [2];
    logic signed [S_W-1:0]        iclamp [2];
    logic signed [INT_W-1:0]      integ_next [2];
    logic signed [DIF_W-1:0]      dif [2];
    logic signed [PID_OP_W-1:0]   op_p [2];
    logic signed [PID_OP_W-1:0]   op_i [2];
    logic signed [PID_OP_W-1:0]   op_d [2];
    logic signed [GAIN_W-1:0]     g_p [2];
    logic signed [GAIN_W-1:0]     g_i [2];
    logic signed [GAIN_W-1:0]     g_d [2];

    lane_ctl_t                    pid_ctl, mix_ctl;
    logic signed [PID_P_W-1:0]    pid_prod [2];
    logic signed [MIX_OP_W-1:0]   mix_op [2];
    logic signed [MIX_P_W-1:0]    mix_prod [2];
    logic signed [OUT_W-1:0]      sat_val [2];
    logic signed [OUT_W-1:0]      steps_a_reg, steps_b_reg;
    logic                         out_valid_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign cnt_last = (cnt_reg == CNT_W'(MULT_BITS - 1));
    assign out_load = (state_reg == S_SAT) && (!out_valid_reg || out_ready);

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg[0]  <= ONE_GAIN;
            ki_reg[0]  <= '0;
            kd_reg[0]  <= '0;
            kp_reg[1]  <= ONE_GAIN;
            ki_reg[1]  <= '0;
            kd_reg[1]  <= '0;
            pid_en_reg <= 1'b0;
            ratio_reg  <= ONE_RATIO;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_KP_X:       kp_reg[0]  <= cfg_wdata;
                CFG_KI_X:       ki_reg[0]  <= cfg_wdata;
                CFG_KD_X:       kd_reg[0]  <= cfg_wdata;
                CFG_KP_Y:       kp_reg[1]  <= cfg_wdata;
                CFG_KI_Y:       ki_reg[1]  <= cfg_wdata;
                CFG_KD_Y:       kd_reg[1]  <= cfg_wdata;
                CFG_PID_ENABLE: pid_en_reg <= cfg_wdata[0];
                CFG_STEP_RATIO: ratio_reg  <= cfg_wdata;
            endcase
        end
    end

    // ---------------------------------------------------------- PID front end
    assign tgt[0] = target_x;
    assign tgt[1] = target_y;
    assign act[0] = actual_x;
    assign act[1] = actual_y;

    // Form error, clamped integral and derivative in the accept cycle; the
    // lanes then only see operands and gain bits.
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            err[a]  = ERR_W'(tgt[a]) - ERR_W'(act[a]);
            isum[a] = S_W'(integ_reg[a]) + S_W'(err[a]);
            priority if (isum[a] > LIM_POS_S)
            begin
                iclamp[a] = LIM_POS_S;
            end
            else if (isum[a] < LIM_NEG_S)
            begin
                iclamp[a] = LIM_NEG_S;
            end
            else
            begin
                iclamp[a] = isum[a];
            end
            integ_next[a] = INT_W'(iclamp[a]);
            dif[a]        = DIF_W'(err[a]) - DIF_W'(prev_reg[a]);

            if (pid_en_reg)
            begin
                op_p[a] = PID_OP_W'(err[a]);
                op_i[a] = PID_OP_W'(integ_next[a]);
                op_d[a] = PID_OP_W'(dif[a]);
                g_p[a]  = kp_reg[a];
                g_i[a]  = ki_reg[a];
                g_d[a]  = kd_reg[a];
            end
            else
            begin
                // pass the target through as target times 1.0
                op_p[a] = PID_OP_W'(tgt[a]);
                op_i[a] = '0;
                op_d[a] = '0;
                g_p[a]  = ONE_GAIN;
                g_i[a]  = '0;
                g_d[a]  = '0;
            end
        end
    end

    // Advance integral and previous error only on a PID update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg[0] <= '0;
            integ_reg[1] <= '0;
            prev_reg[0]  <= '0;
            prev_reg[1]  <= '0;
        end
        else if (accept && pid_en_reg)
        begin
            integ_reg[0] <= integ_next[0];
            integ_reg[1] <= integ_next[1];
            prev_reg[0]  <= err[0];
            prev_reg[1]  <= err[1];
        end
    end

    // ------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_PID;
                    cnt_next   = '0;
                end
            end
            S_PID:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_last)
                begin
                    state_next = S_MIXLD;
                    cnt_next   = '0;
                end
            end
            S_MIXLD:
            begin
                state_next = S_MIX;
                cnt_next   = '0;
            end
            S_MIX:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_last)
                begin
                    state_next = S_RND;
                    cnt_next   = '0;
                end
            end
            S_RND:
            begin
                state_next = S_SAT;
            end
            S_SAT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // ------------------------------------------------------- PID lanes (x, y)
    // Gains are two's complement, so the top bit step subtracts.
    always_comb
    begin
        pid_ctl.load = accept;
        pid_ctl.step = (state_reg == S_PID);
        pid_ctl.neg  = (state_reg == S_PID) && cnt_last;
        mix_ctl.load = (state_reg == S_MIXLD);
        mix_ctl.step = (state_reg == S_MIX);
        mix_ctl.neg  = 1'b0;
    end

    for (genvar a = 0; a < 2; a++)
    begin : g_pid
        pcsm_lane #(
            .OP_W(PID_OP_W)
        ) u_lane (
            .clk  (clk),
            .ctl  (pid_ctl),
            .op0  (op_p[a]),
            .op1  (op_i[a]),
            .op2  (op_d[a]),
            .mul0 (g_p[a]),
            .mul1 (g_i[a]),
            .mul2 (g_d[a]),
            .prod (pid_prod[a])
        );
    end

    // ----------------------------------------------------- mixer lanes (A, B)
    assign mix_op[0] = MIX_OP_W'(pid_prod[0]) + MIX_OP_W'(pid_prod[1]);
    assign mix_op[1] = MIX_OP_W'(pid_prod[0]) - MIX_OP_W'(pid_prod[1]);

    for (genvar a = 0; a < 2; a++)
    begin : g_mix
        pcsm_lane #(
            .OP_W(MIX_OP_W)
        ) u_lane (
            .clk  (clk),
            .ctl  (mix_ctl),
            .op0  (mix_op[a]),
            .op1  ('0),
            .op2  ('0),
            .mul0 (ratio_reg),
            .mul1 ('0),
            .mul2 ('0),
            .prod (mix_prod[a])
        );

        pcsm_round #(
            .P_W (MIX_P_W),
            .SH  (SH)
        ) u_round (
            .clk  (clk),
            .en   (state_reg == S_RND),
            .prod (mix_prod[a]),
            .sat  (sat_val[a])
        );
    end

    // ------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            steps_a_reg <= sat_val[0];
            steps_b_reg <= sat_val[1];
        end
    end

    assign out_valid = out_valid_reg;
    assign steps_a   = steps_a_reg;
    assign steps_b   = steps_b_reg;

    // ------------------------------------------------------------ assertions
    `PCSM_ASSERT_NEXT(a_accept_then_busy, in_valid && in_ready, !in_ready, "request taken while busy")
    `PCSM_ASSERT_SAME(a_integ_x_range, 1'b1, (integ_reg[0] <= INT_POS) && (integ_reg[0] >= INT_NEG), "x integral out of range")
    `PCSM_ASSERT_SAME(a_integ_y_range, 1'b1, (integ_reg[1] <= INT_POS) && (integ_reg[1] >= INT_NEG), "y integral out of range")
    `PCSM_ASSERT_NEXT(a_result_loaded, out_load, out_valid_reg && (state_reg == S_IDLE), "result not loaded")

endmodule
